// ----- sv/pgtq_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pgtq_pkg
// Shared types and constants of the particle/grid transfer block.
// ============================================================================
package pgtq_pkg;

    localparam int CNT_W     = 6;        // 4x4x4 stencil cell counter
    localparam int W_W       = 16;       // Q0.16 weights and kernel values
    localparam int MASS_W    = 48;
    localparam int MOM_W     = 64;
    localparam int QV_W      = 48;       // cell velocity magnitude
    localparam logic [QV_W-1:0] VEL_CAP = 48'h8000_0000_0000;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_AXIS,
        ST_KERN,
        ST_WGT1,
        ST_WGT2,
        ST_TEST,
        ST_SMUL1,
        ST_SMUL2,
        ST_WRITE,
        ST_QCHK,
        ST_DIV,
        ST_QMUL,
        ST_QACC,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic axis_mul;
        logic axis_fin;
        logic kern;
        logic wgt1;
        logic wgt2;
        logic mem_rd;
        logic flag_out;
        logic splat_mul1;
        logic splat_mul2;
        logic mem_wr;
        logic div_start;
        logic query_mul;
        logic query_acc;
        logic cell_next;
        logic out_load;
        logic clear_wr;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic below_thr;
        logic cell_out;
        logic mass_zero;
        logic div_done;
        logic last_cell;
        logic clear_last;
        logic out_busy;
    } status_t;

endpackage

// ----- sv/pgtq_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pgtq_div
// Radix-2 restoring divider: min(floor(dividend * 2^16 / divisor), 2^47).
// ============================================================================
module pgtq_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [47:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);

    logic [47:0] rem_reg;
    logic [47:0] sh_reg;
    logic [47:0] q_reg;
    logic [47:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [48:0] trial;
    logic        ge;

    assign trial = {rem_reg, sh_reg[47]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            cnt_reg <= '0;
            // quotient would not fit 48 bits: go straight to the cap
            if ({16'b0, dividend[63:32]} >= divisor)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= {16'b0, dividend[63:32]};
            sh_reg  <= {dividend[31:0], 16'b0};
            q_reg   <= ({16'b0, dividend[63:32]} >= divisor) ? pgtq_pkg::VEL_CAP : '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 48'(trial - {1'b0, dvs_reg}) : trial[47:0];
            sh_reg  <= {sh_reg[46:0], 1'b0};
            q_reg   <= {q_reg[46:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = (q_reg > pgtq_pkg::VEL_CAP) ? pgtq_pkg::VEL_CAP : q_reg;

endmodule

// ----- sv/pgtq_datapath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pgtq_datapath
// Position scaling, kernel weights, grid store and accumulators.
// ============================================================================
module pgtq_datapath #(
    parameter int GRID_DIM = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pgtq_pkg::cmd_t      cmd,
    output pgtq_pkg::status_t   status,
    input  logic                opcode,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic [31:0]         particle_mass,
    input  logic signed [31:0]  vel_in_x,
    input  logic signed [31:0]  vel_in_y,
    input  logic signed [31:0]  vel_in_z,
    input  logic [31:0]         inverse_cell_size,
    input  logic [15:0]         weight_threshold,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [31:0]         vel_out_x,
    output logic [31:0]         vel_out_y,
    output logic [31:0]         vel_out_z,
    output logic                out_of_grid
);

    localparam int IW    = $clog2(GRID_DIM);
    localparam int CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(CELLS);

    typedef struct packed {
        logic [63:0] mom_z;
        logic [63:0] mom_y;
        logic [63:0] mom_x;
        logic [47:0] mass;
    } cell_t;

    function automatic logic [15:0] kernel_q16(input logic [17:0] x);
        logic [35:0] sq;
        logic [35:0] nv;
        logic [16:0] t;
        logic [33:0] tt;
        logic [33:0] fv;
        logic [15:0] k;
        begin
            sq = 36'(x) * 36'(x);
            nv = (36'd3 << 30) - sq + 36'd32768;
            t  = 17'(18'd98304 - x);
            tt = 34'(t) * 34'(t);
            fv = tt + 34'd65536;
            if (x < 18'd32768)
                k = nv[31:16];
            else if (x < 18'd98304)
                k = fv[32:17];
            else
                k = '0;
            return k;
        end
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            return s[63:0];
        end
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] v);
        begin
            if (!v[63] && (|v[62:31]))
                return 32'h7FFF_FFFF;
            if (v[63] && !(&v[62:31]))
                return 32'h8000_0000;
            return v[31:0];
        end
    endfunction

    // item registers
    logic               query_reg;
    logic [31:0]        pos_reg [3];
    logic [31:0]        vel_reg [3];
    logic [31:0]        mass_reg;
    logic [63:0]        prod_reg [3];
    logic [32:0]        corner_reg [3];
    logic [15:0]        frac_reg [3];
    logic [5:0]         cnt_reg;
    logic [15:0]        ker_reg [3];
    logic               cell_out_reg;
    logic [AW-1:0]      addr_reg;
    logic [15:0]        w1_reg;
    logic [15:0]        w_reg;
    logic [32:0]        wm_reg;
    logic [63:0]        mterm_reg [3];
    logic [63:0]        qprod_reg [3];
    logic               qsign_reg [3];
    logic [63:0]        acc_reg [3];
    logic               outside_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               out_valid_reg;
    logic [31:0]        out_reg [3];
    logic               oog_reg;

    // grid store
    cell_t              mem [CELLS];
    cell_t              rd_reg;
    cell_t              new_cell;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    cell_t              wr_data;

    // stencil cell decode
    logic [1:0]         offs [3];
    logic [33:0]        idx [3];
    logic               in_rng [3];
    logic [17:0]        axis_dst [3];
    logic [AW-1:0]      addr_next;
    logic [32:0]        w1_prod;
    logic [32:0]        w2_prod;
    logic [48:0]        wm_sum;
    logic [63:0]        mom_rd [3];
    logic [63:0]        mom_mag [3];
    logic               div_done [3];
    logic [47:0]        quot [3];
    logic [48:0]        mass_sum;

    assign offs[0] = cnt_reg[5:4];
    assign offs[1] = cnt_reg[3:2];
    assign offs[2] = cnt_reg[1:0];

    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            idx[ax]    = {corner_reg[ax][32], corner_reg[ax]} + {32'b0, offs[ax]};
            in_rng[ax] = !idx[ax][33] && (idx[ax][32:0] < 33'(GRID_DIM));
            unique case (offs[ax])
                2'd0: axis_dst[ax] = {2'b0, frac_reg[ax]} + 18'd65536;
                2'd1: axis_dst[ax] = {2'b0, frac_reg[ax]};
                2'd2: axis_dst[ax] = 18'd65536 - {2'b0, frac_reg[ax]};
                2'd3: axis_dst[ax] = 18'd131072 - {2'b0, frac_reg[ax]};
                default: axis_dst[ax] = '0;
            endcase
        end
    end

    assign addr_next = AW'((AW'(idx[0][IW-1:0]) * AW'(GRID_DIM) + AW'(idx[1][IW-1:0]))
                           * AW'(GRID_DIM) + AW'(idx[2][IW-1:0]));

    assign w1_prod = 33'(ker_reg[0]) * 33'(ker_reg[1]) + 33'd32768;
    assign w2_prod = 33'(w1_reg) * 33'(ker_reg[2]) + 33'd32768;
    assign wm_sum  = 49'(w_reg) * 49'(mass_reg) + 49'd32768;

    assign mom_rd[0] = rd_reg.mom_x;
    assign mom_rd[1] = rd_reg.mom_y;
    assign mom_rd[2] = rd_reg.mom_z;

    assign mass_sum = {1'b0, rd_reg.mass} + 49'(wm_reg);

    always_comb
    begin
        new_cell.mass  = mass_sum[48] ? 48'hFFFF_FFFF_FFFF : mass_sum[47:0];
        new_cell.mom_x = sat_add64(rd_reg.mom_x, mterm_reg[0]);
        new_cell.mom_y = sat_add64(rd_reg.mom_y, mterm_reg[1]);
        new_cell.mom_z = sat_add64(rd_reg.mom_z, mterm_reg[2]);
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            assign mom_mag[g] = mom_rd[g][63] ? (64'd0 - mom_rd[g]) : mom_rd[g];
            pgtq_div u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (cmd.div_start),
                .dividend (mom_mag[g]),
                .divisor  (rd_reg.mass),
                .done     (div_done[g]),
                .quotient (quot[g])
            );
        end
    endgenerate

    // payload registers
    always_ff @(posedge clk)
    begin : p_payload
        logic [31:0] vmag;
        logic [64:0] vprod;
        logic [64:0] vrnd;
        logic [63:0] qrnd;
        if (cmd.load)
        begin
            query_reg  <= opcode;
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            vel_reg[0] <= vel_in_x;
            vel_reg[1] <= vel_in_y;
            vel_reg[2] <= vel_in_z;
            mass_reg   <= particle_mass;
        end
        for (int ax = 0; ax < 3; ax++)
        begin
            if (cmd.axis_mul)
                prod_reg[ax] <= $signed(pos_reg[ax]) * $signed({1'b0, inverse_cell_size});
            if (cmd.axis_fin)
            begin
                corner_reg[ax] <= {prod_reg[ax][63], prod_reg[ax][63:32]} - 33'd1;
                frac_reg[ax]   <= prod_reg[ax][31:16];
            end
            if (cmd.kern)
                ker_reg[ax] <= kernel_q16(axis_dst[ax]);
            if (cmd.splat_mul2)
            begin
                vmag  = vel_reg[ax][31] ? (32'd0 - vel_reg[ax]) : vel_reg[ax];
                vprod = 65'(wm_reg) * 65'(vmag) + 65'd32768;
                vrnd  = vprod >> 16;
                mterm_reg[ax] <= vel_reg[ax][31] ? (64'd0 - vrnd[63:0]) : vrnd[63:0];
            end
            if (cmd.query_mul)
            begin
                qprod_reg[ax] <= 64'(w_reg) * 64'(quot[ax]);
                qsign_reg[ax] <= mom_rd[ax][63];
            end
            if (cmd.query_acc)
            begin
                qrnd = (qprod_reg[ax] + 64'd32768) >> 16;
                acc_reg[ax] <= qsign_reg[ax] ? (acc_reg[ax] - qrnd) : (acc_reg[ax] + qrnd);
            end
            if (cmd.load)
                acc_reg[ax] <= '0;
            if (cmd.out_load)
                out_reg[ax] <= sat32(acc_reg[ax]);
        end
        if (cmd.kern)
        begin
            cell_out_reg <= !(in_rng[0] && in_rng[1] && in_rng[2]);
            addr_reg     <= addr_next;
        end
        if (cmd.wgt1)
            w1_reg <= w1_prod[31:16];
        if (cmd.wgt2)
            w_reg <= w2_prod[31:16];
        if (cmd.splat_mul1)
            wm_reg <= wm_sum[48:16];
        if (cmd.out_load)
            oog_reg <= outside_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            outside_reg   <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                cnt_reg <= '0;
            else if (cmd.cell_next)
                cnt_reg <= cnt_reg + 6'd1;
            if (cmd.load)
                outside_reg <= 1'b0;
            else if (cmd.flag_out)
                outside_reg <= 1'b1;
            if (cmd.clear_wr)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign wr_en   = cmd.clear_wr || cmd.mem_wr;
    assign wr_addr = cmd.clear_wr ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clear_wr ? cell_t'('0) : new_cell;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.mem_rd)
            rd_reg <= mem[addr_reg];
    end

    assign status.is_query   = query_reg;
    assign status.below_thr  = w_reg < weight_threshold;
    assign status.cell_out   = cell_out_reg;
    assign status.mass_zero  = rd_reg.mass == '0;
    assign status.div_done   = div_done[0] && div_done[1] && div_done[2];
    assign status.last_cell  = cnt_reg == 6'd63;
    assign status.clear_last = clr_addr_reg == AW'(CELLS - 1);
    assign status.out_busy   = out_valid_reg;

    assign out_valid   = out_valid_reg;
    assign vel_out_x   = out_reg[0];
    assign vel_out_y   = out_reg[1];
    assign vel_out_z   = out_reg[2];
    assign out_of_grid = oog_reg;

endmodule

// ----- sv/pgtq_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pgtq_ctrl
// Sequencer: clearing sweep, per-item setup and the 64-cell stencil walk.
// ============================================================================
module pgtq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pgtq_pkg::status_t   status,
    output pgtq_pkg::cmd_t      cmd
);

    pgtq_pkg::state_t state_reg;
    pgtq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pgtq_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgtq_pkg::ST_CLEAR: if (status.clear_last) state_next = pgtq_pkg::ST_IDLE;
            pgtq_pkg::ST_IDLE:  if (in_valid) state_next = pgtq_pkg::ST_MUL;
            pgtq_pkg::ST_MUL:   state_next = pgtq_pkg::ST_AXIS;
            pgtq_pkg::ST_AXIS:  state_next = pgtq_pkg::ST_KERN;
            pgtq_pkg::ST_KERN:  state_next = pgtq_pkg::ST_WGT1;
            pgtq_pkg::ST_WGT1:  state_next = pgtq_pkg::ST_WGT2;
            pgtq_pkg::ST_WGT2:  state_next = pgtq_pkg::ST_TEST;
            pgtq_pkg::ST_TEST:
            begin
                priority if (!status.is_query && status.below_thr)
                    state_next = pgtq_pkg::ST_NEXT;
                else if (status.cell_out)
                    state_next = pgtq_pkg::ST_NEXT;
                else if (status.is_query)
                    state_next = pgtq_pkg::ST_QCHK;
                else
                    state_next = pgtq_pkg::ST_SMUL1;
            end
            pgtq_pkg::ST_SMUL1: state_next = pgtq_pkg::ST_SMUL2;
            pgtq_pkg::ST_SMUL2: state_next = pgtq_pkg::ST_WRITE;
            pgtq_pkg::ST_WRITE: state_next = pgtq_pkg::ST_NEXT;
            pgtq_pkg::ST_QCHK:
                state_next = status.mass_zero ? pgtq_pkg::ST_NEXT : pgtq_pkg::ST_DIV;
            pgtq_pkg::ST_DIV:   if (status.div_done) state_next = pgtq_pkg::ST_QMUL;
            pgtq_pkg::ST_QMUL:  state_next = pgtq_pkg::ST_QACC;
            pgtq_pkg::ST_QACC:  state_next = pgtq_pkg::ST_NEXT;
            pgtq_pkg::ST_NEXT:
                state_next = status.last_cell ? pgtq_pkg::ST_DONE : pgtq_pkg::ST_KERN;
            pgtq_pkg::ST_DONE:
                if (!status.is_query || !status.out_busy) state_next = pgtq_pkg::ST_IDLE;
            default: state_next = pgtq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            pgtq_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
            pgtq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pgtq_pkg::ST_MUL:   cmd.axis_mul = 1'b1;
            pgtq_pkg::ST_AXIS:  cmd.axis_fin = 1'b1;
            pgtq_pkg::ST_KERN:  cmd.kern = 1'b1;
            pgtq_pkg::ST_WGT1:  cmd.wgt1 = 1'b1;
            pgtq_pkg::ST_WGT2:  cmd.wgt2 = 1'b1;
            pgtq_pkg::ST_TEST:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.flag_out = status.is_query && status.cell_out;
            end
            pgtq_pkg::ST_SMUL1: cmd.splat_mul1 = 1'b1;
            pgtq_pkg::ST_SMUL2: cmd.splat_mul2 = 1'b1;
            pgtq_pkg::ST_WRITE: cmd.mem_wr = 1'b1;
            pgtq_pkg::ST_QCHK:  cmd.div_start = !status.mass_zero;
            pgtq_pkg::ST_DIV:   cmd = '0;
            pgtq_pkg::ST_QMUL:  cmd.query_mul = 1'b1;
            pgtq_pkg::ST_QACC:  cmd.query_acc = 1'b1;
            pgtq_pkg::ST_NEXT:  cmd.cell_next = !status.last_cell;
            pgtq_pkg::ST_DONE:  cmd.out_load = status.is_query && !status.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- sv/particle_grid_transfer_quadratic_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// particle_grid_transfer_quadratic_top
// Quadratic B-spline particle/grid transfer on a dense GRID_DIM^3 grid.
// ============================================================================
// Usage:
//   Input items arrive on the s_axis channel; tuser carries the opcode
//   (0 splat, 1 query). A splat adds weighted mass and momentum into the
//   4x4x4 cells around the particle and returns nothing. A query returns one
//   item on m_axis: the interpolated velocity and an out-of-grid flag.
//   Two registers sit on the APB port: inverse_cell_size at 0x0 and
//   weight_threshold at 0x4; write them only while the block is idle.
// Sequence:
//   One item at a time: setup in the MUL and AXIS states, then the 64 stencil
//   cells in turn; each cell is skipped, ends after a massless query read,
//   does a splat read-modify-write, or for a query cell with mass waits on the
//   48-step restoring dividers that form momentum/mass; then a closing state.
// Reset:
//   After reset the grid store is swept to zero, one cell per cycle, over all
//   GRID_DIM^3 cells (32768 at the default); no item is taken meanwhile.
// Stall:
//   A query result waits in the output register; a following splat is still
//   taken and worked, and the next query holds at its end until it drains.
// ============================================================================
module particle_grid_transfer_quadratic_top #(
    parameter int GRID_DIM = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    // slave stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // pos_x, pos_y, pos_z, particle_mass, vel_in_x, vel_in_y, vel_in_z
    input  logic [223:0]  s_axis_tdata,
    // opcode
    input  logic          s_axis_tuser,
    // master stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // vel_out_x, vel_out_y, vel_out_z
    output logic [95:0]   m_axis_tdata,
    // out_of_grid
    output logic          m_axis_tuser,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [31:0]        ics_reg;
    logic [15:0]        thr_reg;
    pgtq_pkg::cmd_t     cmd;
    pgtq_pkg::status_t  status;
    logic               cfg_wr;

    // register select is paddr[2]; the low bits alias
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ics_reg <= 32'd65536;
            thr_reg <= 16'd1;
        end
        else if (cfg_wr)
        begin
            if (!paddr[2])
                ics_reg <= pwdata;
            else
                thr_reg <= pwdata[15:0];
        end
    end

    assign prdata = paddr[2] ? {16'b0, thr_reg} : ics_reg;

    pgtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pgtq_datapath #(
        .GRID_DIM (GRID_DIM)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .opcode            (s_axis_tuser),
        .pos_x             (s_axis_tdata[31:0]),
        .pos_y             (s_axis_tdata[63:32]),
        .pos_z             (s_axis_tdata[95:64]),
        .particle_mass     (s_axis_tdata[127:96]),
        .vel_in_x          (s_axis_tdata[159:128]),
        .vel_in_y          (s_axis_tdata[191:160]),
        .vel_in_z          (s_axis_tdata[223:192]),
        .inverse_cell_size (ics_reg),
        .weight_threshold  (thr_reg),
        .out_ready         (m_axis_tready),
        .out_valid         (m_axis_tvalid),
        .vel_out_x         (m_axis_tdata[31:0]),
        .vel_out_y         (m_axis_tdata[63:32]),
        .vel_out_z         (m_axis_tdata[95:64]),
        .out_of_grid       (m_axis_tuser)
    );

    // no item taken during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !s_axis_tready)
        else $error("input ready during grid clear");

    // an accepted item occupies the sequencer on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready straight after accept");

    // a result appears only when a query finishes
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.out_load))
        else $error("result without finished query");

endmodule
